// ===== rtl/escu_pkg.sv =====
// Shared types, constants and arithmetic helpers for the environmental sensor
// compensation unit. Depends on nothing; every other file but escu_ifs uses it.
`default_nettype none

package escu_pkg;

	// Configuration register map (index = paddr[5:3]).
	typedef enum logic [2:0] {
		REG_TEMP      = 3'd0,
		REG_PRESS_LO  = 3'd1,
		REG_PRESS_HI  = 3'd2,
		REG_PRESS_HUM = 3'd3,
		REG_HUM       = 3'd4
	} escu_reg_t;

	localparam int unsigned APB_AW = 6;
	localparam int unsigned APB_DW = 64;

	localparam logic [31:0] C_PRESS_OFS  = 32'd64000;
	localparam logic [31:0] C_PRESS_BASE = 32'd1048576;
	localparam logic [31:0] C_PRESS_MUL  = 32'd3125;
	localparam logic [31:0] C_HUM_OFS    = 32'd76800;
	localparam logic [31:0] C_HUM_BIAS   = 32'd2097152;
	localparam logic [31:0] C_HUM_MAX    = 32'd419430400;
	localparam logic [31:0] C_P1_BIAS    = 32'd32768;
	localparam logic [31:0] C_ROUND_T    = 32'd128;
	localparam logic [31:0] C_ROUND_HA   = 32'd16384;
	localparam logic [31:0] C_ROUND_HB   = 32'd8192;

	// Queue entry handed from the front end to the back end.
	typedef struct packed {
		logic [23:0] temp;
		logic [31:0] fine;
		logic [19:0] raw_p;
		logic [15:0] raw_h;
	} escu_entry_t;

	// Side data that rides along with the pressure divider.
	typedef struct packed {
		logic [23:0] temp;
		logic [16:0] hum;
		logic        halved;
		logic        zero;
	} escu_side_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
		return $unsigned($signed(x) >>> s);
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	function automatic logic [31:0] sext12(input logic [11:0] x);
		return {{20{x[11]}}, x};
	endfunction

	function automatic logic [31:0] sext8(input logic [7:0] x);
		return {{24{x[7]}}, x};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/escu_ifs.sv =====
// Stream interfaces for raw sample sets and compensated readings.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface escu_sample_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic [15:0] raw_humidity;

	modport source(output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
	modport sink(input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface escu_reading_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] temperature_centi;
	logic [31:0]        pressure_pa;
	logic [16:0]        humidity_q10;

	modport source(output valid, temperature_centi, pressure_pa, humidity_q10, input ready);
	modport sink(input valid, temperature_centi, pressure_pa, humidity_q10, output ready);
endinterface

`default_nettype wire

// ===== rtl/env_sensor_compensation_unit.sv =====
// Top level of the environmental sensor compensation unit: configuration
// registers, front end, queue and back end. Depends on escu_pkg and escu_ifs.
//
// The unit takes one raw sample set per transaction (20-bit temperature,
// 20-bit pressure, 16-bit humidity) and returns one transaction with the
// compensated temperature in 0.01 degC, the pressure in Pa (zero when the
// pressure divisor is zero) and the relative humidity in Q7.10 percent.
// It takes a new sample set every clock cycle while the front end is not held
// by a full queue. A sample passes through the front end that forms the fine
// temperature, then the queue, then the back end with its bit-per-stage
// pressure divider. The queue between the two halves holds QUEUE_DEPTH
// transactions, so samples keep being accepted for a while when the result
// side is stalled. Calibration coefficients are written over the APB port at
// byte addresses 0, 8, 16, 24 and 32 (temperature, pressure low, pressure
// high, pressure/humidity, humidity coefficients); they may be changed only
// while no transaction is in flight.
`default_nettype none

module env_sensor_compensation_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	escu_sample_if.sink                            samples,
	escu_reading_if.source                         readings,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [escu_pkg::APB_AW-1:0]       paddr,
	input  wire logic [escu_pkg::APB_DW-1:0]       pwdata,
	output logic      [escu_pkg::APB_DW-1:0]       prdata,
	output logic                                   pready
);

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [47:0] press_hum_q;
	logic [31:0] hum_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;

	// Writes to addresses beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_lo_q    <= '0;
			press_hi_q    <= '0;
			press_hum_q   <= '0;
			hum_q         <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				escu_pkg::REG_TEMP:      temp_coeffs_q <= pwdata[47:0];
				escu_pkg::REG_PRESS_LO:  press_lo_q    <= pwdata;
				escu_pkg::REG_PRESS_HI:  press_hi_q    <= pwdata;
				escu_pkg::REG_PRESS_HUM: press_hum_q   <= pwdata[47:0];
				escu_pkg::REG_HUM:       hum_q         <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			escu_pkg::REG_TEMP:      prdata = {16'b0, temp_coeffs_q};
			escu_pkg::REG_PRESS_LO:  prdata = press_lo_q;
			escu_pkg::REG_PRESS_HI:  prdata = press_hi_q;
			escu_pkg::REG_PRESS_HUM: prdata = {16'b0, press_hum_q};
			escu_pkg::REG_HUM:       prdata = {32'b0, hum_q};
			default:                 prdata = '0;
		endcase
	end

	escu_pkg::escu_entry_t push_data, pop_data;
	logic push_valid, push_full, pop, pop_valid;

	escu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.temp_coeffs (temp_coeffs_q),
		.push_data   (push_data),
		.push_valid  (push_valid),
		.push_full   (push_full)
	);

	escu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid && !push_full),
		.push_data (push_data),
		.full      (push_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.pop_valid (pop_valid)
	);

	escu_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_data            (pop_data),
		.q_valid           (pop_valid),
		.q_pop             (pop),
		.readings          (readings),
		.press_coeffs_low  (press_lo_q),
		.press_coeffs_high (press_hi_q),
		.press_hum_coeffs  (press_hum_q),
		.hum_coeffs        (hum_q)
	);

endmodule

`default_nettype wire

// ===== rtl/escu_front.sv =====
// Front end: accepts sample sets and computes the fine temperature in three stages.
// Depends on escu_pkg and escu_sample_if.
`default_nettype none

module escu_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	escu_sample_if.sink             samples,
	input  wire logic [47:0]        temp_coeffs,
	output escu_pkg::escu_entry_t   push_data,
	output logic                    push_valid,
	input  wire logic               push_full
);

	logic        en;
	logic        v_s1, v_s2, v_s3;
	logic [31:0] t1, t2, t3;
	logic [31:0] a_s1, b_s1;
	logic [19:0] rp_s1, rp_s2, rp_s3;
	logic [15:0] rh_s1, rh_s2, rh_s3;
	logic [31:0] v1_s2, bb_s2;
	logic [31:0] fine_s3;
	logic [31:0] tcent;

	assign t1 = {16'b0, temp_coeffs[15:0]};
	assign t2 = escu_pkg::sext16(temp_coeffs[31:16]);
	assign t3 = escu_pkg::sext16(temp_coeffs[47:32]);

	assign en            = !v_s3 || !push_full;
	assign samples.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= {15'b0, samples.raw_temperature[19:3]} - {t1[30:0], 1'b0};
			b_s1    <= {16'b0, samples.raw_temperature[19:4]} - t1;
			rp_s1   <= samples.raw_pressure;
			rh_s1   <= samples.raw_humidity;
			v1_s2   <= escu_pkg::asr32(a_s1 * t2, 5'd11);
			bb_s2   <= escu_pkg::asr32(b_s1 * b_s1, 5'd12);
			rp_s2   <= rp_s1;
			rh_s2   <= rh_s1;
			fine_s3 <= v1_s2 + escu_pkg::asr32(bb_s2 * t3, 5'd14);
			rp_s3   <= rp_s2;
			rh_s3   <= rh_s2;
		end
	end

	// Temperature in hundredths: (fine * 5 + 128) >> 8.
	assign tcent = escu_pkg::asr32({fine_s3[29:0], 2'b0} + fine_s3 + escu_pkg::C_ROUND_T, 5'd8);

	assign push_valid      = v_s3;
	assign push_data.temp  = tcent[23:0];
	assign push_data.fine  = fine_s3;
	assign push_data.raw_p = rp_s3;
	assign push_data.raw_h = rh_s3;

endmodule

`default_nettype wire

// ===== rtl/escu_queue.sv =====
// Short FIFO between the front end and the back end.
// Depends on escu_pkg.
`default_nettype none

module escu_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire escu_pkg::escu_entry_t push_data,
	output logic                       full,
	input  wire logic                  pop,
	output escu_pkg::escu_entry_t      pop_data,
	output logic                       pop_valid
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	escu_pkg::escu_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> pop_valid)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue fill count did not advance on a write");

endmodule

`default_nettype wire

// ===== rtl/escu_back.sv =====
// Back end: pressure and humidity compensation, a 32-stage pressure divider
// and the output register. Depends on escu_pkg and escu_reading_if.
`default_nettype none

module escu_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire escu_pkg::escu_entry_t q_data,
	input  wire logic                  q_valid,
	output logic                       q_pop,
	escu_reading_if.source             readings,
	input  wire logic [63:0]           press_coeffs_low,
	input  wire logic [63:0]           press_coeffs_high,
	input  wire logic [47:0]           press_hum_coeffs,
	input  wire logic [31:0]           hum_coeffs
);

	localparam int unsigned DIVN = 32;
	localparam int unsigned NSTG = 7 + DIVN + 3;

	logic            en;
	logic [NSTG-1:0] vld_s;

	logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;

	assign p1 = {16'b0, press_coeffs_low[15:0]};
	assign p2 = escu_pkg::sext16(press_coeffs_low[31:16]);
	assign p3 = escu_pkg::sext16(press_coeffs_low[47:32]);
	assign p4 = escu_pkg::sext16(press_coeffs_low[63:48]);
	assign p5 = escu_pkg::sext16(press_coeffs_high[15:0]);
	assign p6 = escu_pkg::sext16(press_coeffs_high[31:16]);
	assign p7 = escu_pkg::sext16(press_coeffs_high[47:32]);
	assign p8 = escu_pkg::sext16(press_coeffs_high[63:48]);
	assign p9 = escu_pkg::sext16(press_hum_coeffs[15:0]);
	assign h1 = {24'b0, press_hum_coeffs[23:16]};
	assign h2 = escu_pkg::sext16(press_hum_coeffs[39:24]);
	assign h3 = {24'b0, press_hum_coeffs[47:40]};
	assign h4 = escu_pkg::sext12(hum_coeffs[11:0]);
	assign h5 = escu_pkg::sext12(hum_coeffs[23:12]);
	assign h6 = escu_pkg::sext8(hum_coeffs[31:24]);

	assign en    = !vld_s[NSTG-1] || readings.ready;
	assign q_pop = q_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-2:0], q_pop};
		end
	end

	// Stages 1..7: pressure terms and the whole humidity formula.
	logic [31:0] pv1, hq;
	logic [31:0] v1_s1, q_s1, hv_s1;
	logic [23:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6, temp_s7;
	logic [19:0] rp_s1, rp_s2, rp_s3;
	logic [15:0] rh_s1;
	logic [31:0] qq;
	logic [31:0] qq11_s2, qq13_s2, v1p5_s2, p2v1_s2, ha_s2, hb6_s2, hb3_s2;
	logic [31:0] v2_s3, v1_s3, hbm_s3, ha_s3;
	logic [31:0] dvs_s4, pn_s4, hbb_s4, ha_s4;
	logic [31:0] hv_s5, dvs_s5, pn_s5;
	logic [31:0] hv_s6, ss_s6, dvs_s6, pn_s6, s6;
	logic [31:0] hsub, hclamp;
	logic [16:0] hum_s7;
	logic [31:0] dvs_s7, dnd_s7;
	logic        halved_s7, zero_s7;

	assign pv1 = escu_pkg::asr32(q_data.fine, 5'd1) - escu_pkg::C_PRESS_OFS;
	assign qq  = q_s1 * q_s1;
	assign hq  = escu_pkg::asr32(hv_s5, 5'd15);
	assign s6  = hv_s6 - escu_pkg::asr32(ss_s6 * h1, 5'd4);
	assign hsub = s6;

	always_comb begin
		hclamp = hsub;
		if (hsub[31]) begin
			hclamp = '0;
		end else if (hsub > escu_pkg::C_HUM_MAX) begin
			hclamp = escu_pkg::C_HUM_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s1   <= pv1;
			q_s1    <= escu_pkg::asr32(pv1, 5'd2);
			hv_s1   <= q_data.fine - escu_pkg::C_HUM_OFS;
			temp_s1 <= q_data.temp;
			rp_s1   <= q_data.raw_p;
			rh_s1   <= q_data.raw_h;

			qq11_s2 <= escu_pkg::asr32(qq, 5'd11);
			qq13_s2 <= escu_pkg::asr32(qq, 5'd13);
			v1p5_s2 <= (v1_s1 * p5) << 1;
			p2v1_s2 <= escu_pkg::asr32(p2 * v1_s1, 5'd1);
			ha_s2   <= escu_pkg::asr32({2'b0, rh_s1, 14'b0} - {h4[11:0], 20'b0}
				- (h5 * hv_s1) + escu_pkg::C_ROUND_HA, 5'd15);
			hb6_s2  <= escu_pkg::asr32(hv_s1 * h6, 5'd10);
			hb3_s2  <= escu_pkg::asr32(hv_s1 * h3, 5'd11) + escu_pkg::C_P1_BIAS;
			temp_s2 <= temp_s1;
			rp_s2   <= rp_s1;

			v2_s3   <= escu_pkg::asr32((qq11_s2 * p6) + v1p5_s2, 5'd2) + {p4[15:0], 16'b0};
			v1_s3   <= escu_pkg::asr32(escu_pkg::asr32(p3 * qq13_s2, 5'd3) + p2v1_s2, 5'd18);
			hbm_s3  <= hb6_s2 * hb3_s2;
			ha_s3   <= ha_s2;
			temp_s3 <= temp_s2;
			rp_s3   <= rp_s2;

			dvs_s4  <= escu_pkg::asr32((escu_pkg::C_P1_BIAS + v1_s3) * p1, 5'd15);
			pn_s4   <= ((escu_pkg::C_PRESS_BASE - {12'b0, rp_s3})
				- escu_pkg::asr32(v2_s3, 5'd12)) * escu_pkg::C_PRESS_MUL;
			hbb_s4  <= escu_pkg::asr32((escu_pkg::asr32(hbm_s3, 5'd10) + escu_pkg::C_HUM_BIAS)
				* h2 + escu_pkg::C_ROUND_HB, 5'd14);
			ha_s4   <= ha_s3;
			temp_s4 <= temp_s3;

			hv_s5   <= ha_s4 * hbb_s4;
			dvs_s5  <= dvs_s4;
			pn_s5   <= pn_s4;
			temp_s5 <= temp_s4;

			ss_s6   <= escu_pkg::asr32(hq * hq, 5'd7);
			hv_s6   <= hv_s5;
			dvs_s6  <= dvs_s5;
			pn_s6   <= pn_s5;
			temp_s6 <= temp_s5;

			hum_s7    <= hclamp[28:12];
			dvs_s7    <= dvs_s6;
			zero_s7   <= (dvs_s6 == '0);
			halved_s7 <= pn_s6[31];
			dnd_s7    <= pn_s6[31] ? pn_s6 : {pn_s6[30:0], 1'b0};
			temp_s7   <= temp_s6;
		end
	end

	// Restoring divider, one quotient bit per stage.
	logic [31:0]          div_rem_s  [DIVN];
	logic [31:0]          div_num_s  [DIVN];
	logic [31:0]          div_dvs_s  [DIVN];
	escu_pkg::escu_side_t div_side_s [DIVN];

	for (genvar k = 0; k < DIVN; k++) begin : g_div
		logic [31:0]          rin, nin, din;
		escu_pkg::escu_side_t sin;
		logic [32:0]          trial, diff;
		logic                 ge;

		if (k == 0) begin : g_first
			assign rin         = '0;
			assign nin         = dnd_s7;
			assign din         = dvs_s7;
			assign sin.temp    = temp_s7;
			assign sin.hum     = hum_s7;
			assign sin.halved  = halved_s7;
			assign sin.zero    = zero_s7;
		end else begin : g_next
			assign rin = div_rem_s[k-1];
			assign nin = div_num_s[k-1];
			assign din = div_dvs_s[k-1];
			assign sin = div_side_s[k-1];
		end

		assign trial = {rin, nin[31]};
		assign diff  = trial - {1'b0, din};
		assign ge    = (trial >= {1'b0, din});

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[k]  <= ge ? diff[31:0] : trial[31:0];
				div_num_s[k]  <= {nin[30:0], ge};
				div_dvs_s[k]  <= din;
				div_side_s[k] <= sin;
			end
		end
	end

	// Final pressure correction and output register.
	logic [31:0]          quot, pdiv, p3b;
	logic [31:0]          pp_p1, m1_p1, m2_p1, m2_p2, m3_p2, pp_p2;
	escu_pkg::escu_side_t side_p1, side_p2;
	logic signed [23:0]   temp_o;
	logic [31:0]          pres_o;
	logic [16:0]          hum_o;

	assign quot = div_num_s[DIVN-1];
	assign pdiv = div_side_s[DIVN-1].halved ? {quot[30:0], 1'b0} : quot;
	assign p3b  = pdiv >> 3;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_p1   <= pdiv;
			m1_p1   <= (p3b * p3b) >> 13;
			m2_p1   <= escu_pkg::asr32((pdiv >> 2) * p8, 5'd13);
			side_p1 <= div_side_s[DIVN-1];

			m3_p2   <= escu_pkg::asr32(p9 * m1_p1, 5'd12);
			m2_p2   <= m2_p1;
			pp_p2   <= pp_p1;
			side_p2 <= side_p1;

			temp_o  <= $signed(side_p2.temp);
			hum_o   <= side_p2.hum;
			pres_o  <= side_p2.zero ? '0
				: pp_p2 + escu_pkg::asr32(m3_p2 + m2_p2 + p7, 5'd4);
		end
	end

	assign readings.valid             = vld_s[NSTG-1];
	assign readings.temperature_centi = temp_o;
	assign readings.pressure_pa       = pres_o;
	assign readings.humidity_q10      = hum_o;

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		readings.valid |-> readings.humidity_q10 <= 17'd102400)
		else $error("humidity beyond clamp");
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(readings.valid && $past(en) && $past(side_p2.zero)) |-> readings.pressure_pa == '0)
		else $error("zero divisor did not give zero pressure");
	a_pop_gate: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> en)
		else $error("queue popped while back end stalled");

endmodule

`default_nettype wire

// ===== bench/tb_env_sensor_compensation_unit.sv =====
// Self-checking testbench for env_sensor_compensation_unit.
// Depends on escu_pkg and escu_ifs from the RTL; predicts every reading and compares it.
`timescale 1ns / 1ps

module tb_env_sensor_compensation_unit;

	// One expected reading.
	typedef struct packed {
		logic [23:0] temp;
		logic [31:0] press;
		logic [16:0] hum;
	} reading_t;

	localparam int LATENCY    = 46;
	localparam int WATCH_MAX  = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [escu_pkg::APB_AW-1:0] paddr = '0;
	logic [escu_pkg::APB_DW-1:0] pwdata = '0;
	logic [escu_pkg::APB_DW-1:0] prdata;
	logic pready;

	escu_sample_if  samples();
	escu_reading_if readings();

	env_sensor_compensation_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples.sink),
		.readings(readings.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Model copy of the calibration registers.
	logic [63:0] cal_regs [5];

	reading_t expected_readings [$];
	int mismatches = 0;
	int readings_seen = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;

	// Idling controls. The sender side gaps are drawn inside the send task;
	// the receiver side runs in its own process below.
	bit idling_on = 1'b1;
	int long_hold = 0;

	initial begin
		samples.valid = 1'b0;
		samples.raw_temperature = '0;
		samples.raw_pressure = '0;
		samples.raw_humidity = '0;
		readings.ready = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] sar(input logic [31:0] x, input int s);
		return $unsigned($signed(x) >>> s);
	endfunction

	function automatic logic [31:0] sgn(input logic [63:0] r, input int lo, input int bits);
		logic [31:0] v;
		v = 32'(r >> lo) & ((32'd1 << bits) - 1);
		if (v[bits-1])
			v = v | ~((32'd1 << bits) - 1);
		return v;
	endfunction

	function automatic logic [31:0] uns(input logic [63:0] r, input int lo, input int bits);
		return 32'(r >> lo) & ((32'd1 << bits) - 1);
	endfunction

	// Compensated reading for one raw sample set, 32-bit wrapping arithmetic throughout.
	function automatic reading_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p,
			input logic [15:0] adc_h);
		reading_t r;
		logic [31:0] t1, t2, t3, a, b, fine, v1, v2, q, p;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6, v, s;
		t1 = uns(cal_regs[0], 0, 16);
		t2 = sgn(cal_regs[0], 16, 16);
		t3 = sgn(cal_regs[0], 32, 16);
		a = ({12'd0, adc_t} >> 3) - (t1 << 1);
		b = ({12'd0, adc_t} >> 4) - t1;
		fine = sar(a * t2, 11) + sar(sar(b * b, 12) * t3, 14);
		r.temp = 24'(sar(fine * 32'd5 + 32'd128, 8));

		p1 = uns(cal_regs[1], 0, 16);
		p2 = sgn(cal_regs[1], 16, 16);
		p3 = sgn(cal_regs[1], 32, 16);
		p4 = sgn(cal_regs[1], 48, 16);
		p5 = sgn(cal_regs[2], 0, 16);
		p6 = sgn(cal_regs[2], 16, 16);
		p7 = sgn(cal_regs[2], 32, 16);
		p8 = sgn(cal_regs[2], 48, 16);
		p9 = sgn(cal_regs[3], 0, 16);
		v1 = sar(fine, 1) - 32'd64000;
		q = sar(v1, 2);
		v2 = sar(q * q, 11) * p6;
		v2 = v2 + ((v1 * p5) << 1);
		v2 = sar(v2, 2) + (p4 << 16);
		v1 = sar(sar(p3 * sar(q * q, 13), 3) + sar(p2 * v1, 1), 18);
		v1 = sar((32'd32768 + v1) * p1, 15);
		if (v1 == 0) begin
			r.press = 0;
		end else begin
			p = ((32'd1048576 - {12'd0, adc_p}) - sar(v2, 12)) * 32'd3125;
			if (!p[31])
				p = (p << 1) / v1;
			else
				p = (p / v1) * 2;
			v1 = sar(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
			v2 = sar((p >> 2) * p8, 13);
			r.press = p + sar(v1 + v2 + p7, 4);
		end

		h1 = uns(cal_regs[3], 16, 8);
		h2 = sgn(cal_regs[3], 24, 16);
		h3 = uns(cal_regs[3], 40, 8);
		h4 = sgn(cal_regs[4], 0, 12);
		h5 = sgn(cal_regs[4], 12, 12);
		h6 = sgn(cal_regs[4], 24, 8);
		v = fine - 32'd76800;
		a = sar((({16'd0, adc_h} << 14) - (h4 << 20) - (h5 * v)) + 32'd16384, 15);
		b = sar(v * h6, 10) * (sar(v * h3, 11) + 32'd32768);
		b = (sar(b, 10) + 32'd2097152) * h2 + 32'd8192;
		b = sar(b, 14);
		v = a * b;
		s = sar(v, 15);
		v = v - sar(sar(s * s, 7) * h1, 4);
		if (v[31])
			v = 0;
		if (v > 32'd419430400)
			v = 32'd419430400;
		r.hum = 17'(v >> 12);
		return r;
	endfunction

	// Receiver: random stall bursts, plus one long hold-off when requested.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				readings.ready <= 1'b0;
				long_hold = long_hold - 1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				readings.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				readings.ready <= 1'b1;
			end
		end
	end

	// Checks each accepted reading against the oldest prediction.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && readings.valid && readings.ready) begin
			readings_seen++;
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reading t=%0d p=%0d h=%0d",
						readings.temperature_centi, readings.pressure_pa,
						readings.humidity_q10);
			end else begin
				want = expected_readings.pop_front();
				if (readings.temperature_centi !== want.temp
						|| readings.pressure_pa !== want.press
						|| readings.humidity_q10 !== want.hum) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reading mismatch: exp t=%0d p=%0d h=%0d, got t=%0d p=%0d h=%0d",
							$signed(want.temp), want.press, want.hum,
							readings.temperature_centi, readings.pressure_pa,
							readings.humidity_q10);
				end
			end
		end
	end

	// Watchdog: ends the run when nothing is accepted for too long.
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (readings.valid && readings.ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCH_MAX && !timed_out) begin
			timed_out = 1'b1;
			$display("[env_sensor_compensation_unit] ERROR");
			$finish;
		end
	end

	// Writes one calibration register over APB, setup then access.
	task automatic write_cal(input escu_pkg::escu_reg_t idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= escu_pkg::APB_AW'(idx) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cal_regs[idx] = value;
	endtask

	// Offers one sample set, waits for its acceptance and records the prediction.
	task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp, input logic [15:0] rh);
		int gap;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.raw_temperature <= rt;
		samples.raw_pressure <= rp;
		samples.raw_humidity <= rh;
		expected_readings.push_back(compensate(rt, rp, rh));
		do @(posedge clk); while (!samples.ready);
	endtask

	task automatic end_burst();
		samples.valid <= 1'b0;
	endtask

	// Waits until every expected reading has come, then lets the pipeline drain.
	task automatic drain();
		end_burst();
		while (expected_readings.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Calibration set close to a typical factory part.
	task automatic load_typical_cal();
		write_cal(escu_pkg::REG_TEMP, {16'hFC18, 16'd26435, 16'd27504});
		write_cal(escu_pkg::REG_PRESS_LO, {16'd2855, 16'hD0B9, 16'hF5A6, 16'd36477});
		write_cal(escu_pkg::REG_PRESS_HI, {16'hFFF4, 16'd15500, 16'hFFF9, 16'd140});
		write_cal(escu_pkg::REG_PRESS_HUM, {8'd0, 16'd362, 8'd75, 16'd6000});
		write_cal(escu_pkg::REG_HUM, {8'd30, 12'd50, 12'd314});
	endtask

	task automatic load_random_cal();
		write_cal(escu_pkg::REG_TEMP, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
		write_cal(escu_pkg::REG_PRESS_LO, {$urandom, $urandom});
		write_cal(escu_pkg::REG_PRESS_HI, {$urandom, $urandom});
		write_cal(escu_pkg::REG_PRESS_HUM, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
		write_cal(escu_pkg::REG_HUM, {32'd0, $urandom});
	endtask

	// Extremes of the raw fields, zero divisor with reset coefficients included.
	task automatic test_directed_extremes();
		send_sample(20'd0, 20'd0, 16'd0);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		drain();
		load_typical_cal();
		send_sample(20'd519888, 20'd415148, 16'd30000);
		send_sample(20'd0, 20'd0, 16'd0);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
		send_sample(20'h55555, 20'hAAAAA, 16'h5555);
		// Very dry and very wet raw humidity to hit both clamp limits.
		send_sample(20'd519888, 20'd415148, 16'd0);
		send_sample(20'd519888, 20'd415148, 16'hFFFF);
		drain();
		// All-ones coefficients: negative divisor path and wrap-around.
		write_cal(escu_pkg::REG_TEMP, 64'hFFFF_FFFF_FFFF);
		write_cal(escu_pkg::REG_PRESS_LO, '1);
		write_cal(escu_pkg::REG_PRESS_HI, '1);
		write_cal(escu_pkg::REG_PRESS_HUM, 64'hFFFF_FFFF_FFFF);
		write_cal(escu_pkg::REG_HUM, 64'hFFFF_FFFF);
		send_sample(20'd0, 20'd0, 16'd0);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_sample(20'd519888, 20'd415148, 16'd30000);
		drain();
		// Most negative signed coefficients, largest unsigned ones.
		write_cal(escu_pkg::REG_TEMP, {16'h8000, 16'h8000, 16'hFFFF});
		write_cal(escu_pkg::REG_PRESS_LO, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF});
		write_cal(escu_pkg::REG_PRESS_HI, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
		write_cal(escu_pkg::REG_PRESS_HUM, {8'hFF, 16'h8000, 8'hFF, 16'h7FFF});
		write_cal(escu_pkg::REG_HUM, {8'h80, 12'h800, 12'h7FF});
		send_sample(20'd0, 20'd0, 16'd0);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_sample(20'd300000, 20'd500000, 16'd20000);
		drain();
	endtask

	// Random sample sets, mostly near realistic values, over several coefficient sets.
	task automatic test_random_samples(input int count);
		logic [19:0] rt, rp;
		logic [15:0] rh;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				rt = 20'($urandom_range(380000, 640000));
				rp = 20'($urandom_range(200000, 600000));
				rh = 16'($urandom_range(15000, 40000));
			end else begin
				rt = 20'($urandom);
				rp = 20'($urandom);
				rh = 16'($urandom);
			end
			send_sample(rt, rp, rh);
		end
	endtask

	// Receiver holds off long enough for the queue to fill and stall the input.
	task automatic test_backpressure();
		long_hold = 200;
		test_random_samples(80);
		drain();
	endtask

	initial begin
		for (int i = 0; i < 5; i++)
			cal_regs[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_extremes();
		load_typical_cal();
		test_random_samples(735);
		drain();
		test_backpressure();
		repeat (3) begin
			load_random_cal();
			test_random_samples(250);
			drain();
		end
		load_typical_cal();
		idling_on = 1'b0;
		test_random_samples(170);
		drain();
		$display("Covered raw extremes, zero and negative divisors, humidity clamps,");
		$display("%0d readings over typical, random and extreme calibrations with stalls.",
			readings_seen);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("[env_sensor_compensation_unit] OK");
		else
			$display("[env_sensor_compensation_unit] ERROR");
		$finish;
	end

endmodule
